FILE: rtl/bpcm_pkg.sv
// ----------------------------------------------------------------------------
// bpcm_pkg
// Shared widths, register indexes and reset values of the big pixel
// coordinate map.
// ----------------------------------------------------------------------------
package bpcm_pkg;

  localparam int MaxBigDef    = 4;
  localparam int IndexBitsDef = 10;

  localparam int PitchW = 16;
  localparam int NpixW  = 11;
  localparam int ListW  = 40;
  localparam int CntW   = 3;
  localparam int CfgW   = 40;
  localparam int CfgIdxW = 3;

  localparam int PosW = 27;
  localparam int PixW = 19;
  localparam int OffW = 26;

  // register stages inside one axis slice
  localparam int AxisLat = 11;

  localparam logic [CfgIdxW-1:0] RegPitchX   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPitchY   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPixelsX  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPixelsY  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBigCols  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegBigRows  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegBigColN  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegBigRowN  = 3'd7;

  localparam logic [PitchW-1:0] PitchRst = 16'd3520;
  localparam logic [NpixW-1:0]  NpixRst  = 11'd256;

  typedef struct packed {
    logic [PitchW-1:0] pitch;
    logic [NpixW-1:0]  npix;
    logic [ListW-1:0]  list;
    logic [CntW-1:0]   cnt;
  } axis_cfg_t;

endpackage

FILE: rtl/bpcm_axis.sv
// ----------------------------------------------------------------------------
// bpcm_axis
// One axis of the coordinate map: position to fractional pixel through a
// pipelined divider, and pixel to position through two multipliers.
// ----------------------------------------------------------------------------
module bpcm_axis import bpcm_pkg::*; #(
  parameter int MAX_BIG    = MaxBigDef,
  parameter int INDEX_BITS = IndexBitsDef
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  axis_cfg_t              cfg_i,
  input  logic signed [PosW-1:0] pos_i,
  input  logic signed [PixW-1:0] c_i,
  output logic signed [PixW-1:0] pix_o,
  output logic signed [PosW-1:0] pos_o,
  output logic signed [OffW-1:0] off_o
);

  localparam int QW    = 36;
  localparam int RW    = PitchW + 1;
  localparam int DStep = 6;
  localparam int NDS   = QW / DStep;
  localparam int TW    = 22;
  localparam int DW    = 24;
  localparam int LW    = $clog2(2 * MAX_BIG + 1);
  localparam int ADL   = AxisLat - 4;
  localparam int SizeW = PitchW + NpixW + 1;

  logic [PitchW-1:0] pitch;
  logic [CntW-1:0]   cnt;
  logic [SizeW-1:0]  size_q;

  assign pitch = (cfg_i.pitch == '0) ? PitchW'(1) : cfg_i.pitch;
  assign cnt   = (cfg_i.cnt > CntW'(MAX_BIG)) ? CntW'(MAX_BIG) : cfg_i.cnt;

  always_ff @(posedge clk_i) begin
    size_q <= SizeW'(pitch * (NpixW + 1)'(32'(cfg_i.npix) + 32'(cnt)));
  end

  function automatic logic [RW+QW-1:0] div_step(logic [RW-1:0] r, logic [QW-1:0] aq,
                                                logic [PitchW-1:0] p);
    logic [RW-1:0] rr;
    logic [QW-1:0] a;
    logic [RW:0]   diff;
    rr = r;
    a  = aq;
    for (int k = 0; k < DStep; k++) begin
      rr   = {rr[RW-2:0], a[QW-1]};
      a    = {a[QW-2:0], 1'b0};
      diff = {1'b0, rr} - {2'b0, p};
      if (!diff[RW]) begin
        rr   = diff[RW-1:0];
        a[0] = 1'b1;
      end
    end
    return {rr, a};
  endfunction

  // stage 1: capture
  logic signed [PosW-1:0] pos_q;
  logic signed [PixW-1:0] c_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_q <= pos_i;
      c_q   <= c_i;
    end
  end

  // stage 2: numerator magnitude, and pixel-to-position prep
  logic signed [SizeW+3:0] num_v;
  logic signed [SizeW+10:0] num_s;
  logic [QW-1:0]           mag_d, mag_q;
  logic                    neg_d, neg_q;
  logic signed [PixW+1:0]  cp;
  logic signed [PixW+2:0]  u_d, u_q;
  logic signed [8:0]       dd_d, dd_q;

  always_comb begin
    logic [LW-1:0]          left;
    logic                   big;
    logic signed [PixW+2:0] bs;
    logic signed [PixW+2:0] df;
    num_v = (SizeW+4)'(pos_q) * 2 + $signed({4'b0, size_q});
    num_s = (SizeW+11)'(num_v) <<< 7;
    neg_d = num_s < 0;
    mag_d = neg_d ? QW'(-num_s) : QW'(num_s);
    cp    = (PixW+2)'(c_q) + 128;
    left  = '0;
    big   = 1'b0;
    for (int i = 0; i < MAX_BIG; i++) begin
      bs = $signed((PixW+3)'(cfg_i.list[i*INDEX_BITS +: INDEX_BITS])) <<< 8;
      df = (PixW+3)'(c_q) - bs;
      if (i < int'(cnt)) begin
        if (bs + 256 <= (PixW+3)'(cp)) left = left + LW'(1);
        if (df >= -127 && df <= 127) big = 1'b1;
      end
    end
    u_d  = (PixW+3)'(cp) + $signed((PixW+3)'(left) <<< 8)
         + (big ? $signed((PixW+3)'(cp[7:0])) : '0);
    dd_d = $signed({1'b0, cp[7:0]}) - 9'sd128;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
      u_q   <= u_d;
      dd_q  <= dd_d;
    end
  end

  // divider stages, DStep quotient bits each
  logic [QW-1:0] aq_q  [NDS];
  logic [RW-1:0] r_q   [NDS];
  logic          dn_q  [NDS];

  for (genvar s = 0; s < NDS; s++) begin : g_div
    logic [RW+QW-1:0] nxt;
    logic             dn_in;
    if (s == 0) begin : g_first
      assign nxt   = div_step('0, mag_q, pitch);
      assign dn_in = neg_q;
    end else begin : g_rest
      assign nxt   = div_step(r_q[s-1], aq_q[s-1], pitch);
      assign dn_in = dn_q[s-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s]  <= nxt[RW+QW-1:QW];
        aq_q[s] <= nxt[QW-1:0];
        dn_q[s] <= dn_in;
      end
    end
  end

  // floor correction and clamp of the grid column
  logic signed [QW+1:0] qs;
  logic signed [TW-1:0] t_d, t_q;

  always_comb begin
    logic signed [QW+1:0] qq;
    qq = $signed({2'b0, aq_q[NDS-1]});
    if (dn_q[NDS-1]) qs = -qq - ((r_q[NDS-1] != '0) ? 1 : 0) - 128;
    else             qs = qq - 128;
    if (qs > (QW+2)'((1 <<< (TW-1)) - 1))  t_d = TW'((1 <<< (TW-1)) - 1);
    else if (qs < -(QW+2)'(1 <<< (TW-1))) t_d = TW'(-(1 <<< (TW-1)));
    else                                   t_d = TW'(qs);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) t_q <= t_d;
  end

  // big pixel halves: left count and hit
  logic [LW-1:0]          left_d, left_q;
  logic                   hit_d, hit_q;
  logic signed [DW-1:0]   dsel_d, dsel_q;
  logic [INDEX_BITS-1:0]  bsel_d, bsel_q;
  logic signed [TW-1:0]   t2_q;

  always_comb begin
    logic signed [DW-1:0] h0;
    logic signed [DW-1:0] d0;
    logic signed [DW-1:0] d1;
    left_d = '0;
    hit_d  = 1'b0;
    dsel_d = '0;
    bsel_d = '0;
    for (int i = 0; i < MAX_BIG; i++) begin
      h0 = $signed(DW'((32'(cfg_i.list[i*INDEX_BITS +: INDEX_BITS]) + i) * 256));
      d0 = DW'(t_q) - h0;
      d1 = d0 - 256;
      if (i < int'(cnt)) begin
        if (d0 >= 0) left_d = left_d + LW'(1);
        if (d1 >= 0) left_d = left_d + LW'(1);
        if ((d0 >= -127 && d0 <= 127) || (d1 >= -127 && d1 <= 127)) begin
          hit_d  = 1'b1;
          dsel_d = d0;
          bsel_d = cfg_i.list[i*INDEX_BITS +: INDEX_BITS];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      left_q <= left_d;
      hit_q  <= hit_d;
      dsel_q <= dsel_d;
      bsel_q <= bsel_d;
      t2_q   <= t_q;
    end
  end

  // column result
  logic signed [DW-1:0]   res;
  logic signed [PixW-1:0] pix_q;

  always_comb begin
    if (hit_q) res = (dsel_q >>> 1) + $signed(DW'(bsel_q) <<< 8) - 64;
    else       res = DW'(t2_q) - $signed(DW'(left_q) <<< 7);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (res > DW'((1 <<< (PixW-1)) - 1))   pix_q <= PixW'((1 <<< (PixW-1)) - 1);
      else if (res < -DW'(1 <<< (PixW-1)))  pix_q <= PixW'(-(1 <<< (PixW-1)));
      else                                  pix_q <= PixW'(res);
    end
  end

  assign pix_o = pix_q;

  // pixel to position: multiply, then scale and saturate
  logic signed [PitchW+PixW+3:0] m1_q;
  logic signed [PitchW+9:0]      m2_q;
  logic signed [PitchW+PixW+5:0] pr;
  logic signed [PosW-1:0]        ap_q  [ADL+1];
  logic signed [OffW-1:0]        ao_q  [ADL+1];

  assign pr = (((PitchW+PixW+6)'(m1_q) <<< 1)
             - $signed((PitchW+PixW+6)'(size_q) <<< 8)) >>> 9;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q <= $signed({1'b0, pitch}) * u_q;
      m2_q <= $signed({1'b0, pitch}) * dd_q;
      if (pr > (PitchW+PixW+6)'((1 <<< (PosW-1)) - 1))  ap_q[0] <= PosW'((1 <<< (PosW-1)) - 1);
      else if (pr < -(PitchW+PixW+6)'(1 <<< (PosW-1))) ap_q[0] <= PosW'(-(1 <<< (PosW-1)));
      else                                             ap_q[0] <= PosW'(pr);
      ao_q[0] <= OffW'(m2_q >>> 8);
      for (int k = 1; k <= ADL; k++) begin
        ap_q[k] <= ap_q[k-1];
        ao_q[k] <= ao_q[k-1];
      end
    end
  end

  assign pos_o = ap_q[ADL];
  assign off_o = ao_q[ADL];

endmodule

FILE: rtl/big_pixel_coordinate_map_unit.sv
// ----------------------------------------------------------------------------
// big_pixel_coordinate_map_unit
// Converts local positions to fractional column/row and back on a sensor
// with double-size pixels.
//
//   channel  valid        stall         payload
//   in       in_valid_i   in_stall_o    action_i, pos_x_i, pos_y_i,
//                                       column_in_i, row_in_i
//   out      out_valid_o  out_stall_i   column_out_o, row_out_o, pos_x_out_o,
//                                       pos_y_out_o, in_pixel_x_o, in_pixel_y_o
//   cfg      cfg_we_i     -             cfg_index_i, cfg_data_i
//
// one item per cycle while the output is not stalled; the item is captured at
// the accepting edge and passes capture, prep, the six-stage pipelined divider
// (6 quotient bits per stage), clamp, hit, column and output stages.
// reset loads the default geometry; the pipeline holds no items after reset.
// a stalled output item freezes the whole pipeline and stalls the input.
// ----------------------------------------------------------------------------
module big_pixel_coordinate_map_unit import bpcm_pkg::*; #(
  parameter int MAX_BIG    = MaxBigDef,
  parameter int INDEX_BITS = IndexBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgW-1:0]           cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      action_i,
  input  logic signed [PosW-1:0]    pos_x_i,
  input  logic signed [PosW-1:0]    pos_y_i,
  input  logic signed [PixW-1:0]    column_in_i,
  input  logic signed [PixW-1:0]    row_in_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [PixW-1:0]    column_out_o,
  output logic signed [PixW-1:0]    row_out_o,
  output logic signed [PosW-1:0]    pos_x_out_o,
  output logic signed [PosW-1:0]    pos_y_out_o,
  output logic signed [OffW-1:0]    in_pixel_x_o,
  output logic signed [OffW-1:0]    in_pixel_y_o
);

  axis_cfg_t cfg_x_q, cfg_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_x_q <= '{pitch: PitchRst, npix: NpixRst, list: '0, cnt: '0};
      cfg_y_q <= '{pitch: PitchRst, npix: NpixRst, list: '0, cnt: '0};
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegPitchX:  cfg_x_q.pitch <= cfg_data_i[PitchW-1:0];
        RegPitchY:  cfg_y_q.pitch <= cfg_data_i[PitchW-1:0];
        RegPixelsX: cfg_x_q.npix  <= cfg_data_i[NpixW-1:0];
        RegPixelsY: cfg_y_q.npix  <= cfg_data_i[NpixW-1:0];
        RegBigCols: cfg_x_q.list  <= cfg_data_i[ListW-1:0];
        RegBigRows: cfg_y_q.list  <= cfg_data_i[ListW-1:0];
        RegBigColN: cfg_x_q.cnt   <= cfg_data_i[CntW-1:0];
        RegBigRowN: cfg_y_q.cnt   <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances when the output register is free or taken
  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  logic vld_q [AxisLat];
  logic act_q [AxisLat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < AxisLat; k++) vld_q[k] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < AxisLat; k++) vld_q[k] <= vld_q[k-1];
      out_valid_q <= vld_q[AxisLat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      act_q[0] <= action_i;
      for (int k = 1; k < AxisLat; k++) act_q[k] <= act_q[k-1];
    end
  end

  logic signed [PixW-1:0] pix_x, pix_y;
  logic signed [PosW-1:0] pos_x, pos_y;
  logic signed [OffW-1:0] off_x, off_y;

  bpcm_axis #(.MAX_BIG(MAX_BIG), .INDEX_BITS(INDEX_BITS)) u_axis_x (
    .clk_i (clk_i),
    .en_i  (en),
    .cfg_i (cfg_x_q),
    .pos_i (pos_x_i),
    .c_i   (column_in_i),
    .pix_o (pix_x),
    .pos_o (pos_x),
    .off_o (off_x)
  );

  bpcm_axis #(.MAX_BIG(MAX_BIG), .INDEX_BITS(INDEX_BITS)) u_axis_y (
    .clk_i (clk_i),
    .en_i  (en),
    .cfg_i (cfg_y_q),
    .pos_i (pos_y_i),
    .c_i   (row_in_i),
    .pix_o (pix_y),
    .pos_o (pos_y),
    .off_o (off_y)
  );

  logic signed [PixW-1:0] col_q, row_q;
  logic signed [PosW-1:0] px_q, py_q;
  logic signed [OffW-1:0] ix_q, iy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      col_q <= act_q[AxisLat-1] ? '0 : pix_x;
      row_q <= act_q[AxisLat-1] ? '0 : pix_y;
      px_q  <= act_q[AxisLat-1] ? pos_x : '0;
      py_q  <= act_q[AxisLat-1] ? pos_y : '0;
      ix_q  <= act_q[AxisLat-1] ? off_x : '0;
      iy_q  <= act_q[AxisLat-1] ? off_y : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign column_out_o = col_q;
  assign row_out_o    = row_q;
  assign pos_x_out_o  = px_q;
  assign pos_y_out_o  = py_q;
  assign in_pixel_x_o = ix_q;
  assign in_pixel_y_o = iy_q;

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> vld_q[0])
    else $error("accepted item did not enter the pipeline");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(col_q) && $stable(px_q))
    else $error("stalled output changed");

  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (col_q != '0 || row_q != '0) |-> px_q == '0 && py_q == '0
      && ix_q == '0 && iy_q == '0)
    else $error("both result groups active");

endmodule
